[sv/assert_macros.svh]
// assertion macros included by the syt timestamp generator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SYT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SYT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/syt_pkg.sv]
// constants, codes and helpers for the syt timestamp generator
package syt_pkg;

   localparam int unsigned TICKS_PER_CYCLE   = 3072;
   localparam int unsigned CYCLES_PER_SECOND = 8000;
   localparam int unsigned SYT_WRAP_TICKS    = 49152;
   // eight seconds counted in bus cycles
   localparam int unsigned WRAP_CYCLES       = 64000;
   // bias in whole bus cycles that keeps the nudge delta positive
   localparam int unsigned NUDGE_BIAS_CYCLES = 11;
   localparam int unsigned NUDGE_BIAS_TICKS  = NUDGE_BIAS_CYCLES * TICKS_PER_CYCLE;
   // ceil(2^20 / 3), exact quotient by three for 18-bit values
   localparam int unsigned DIV3_MUL          = 349526;

   localparam int unsigned TK_W       = 12;
   localparam int unsigned CYC_W      = 16;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 28;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [RSP_DATA_W-1:0] NO_INFO = 16'hFFFF;

   typedef enum logic [2:0] {
      CMD_SEED  = 3'd0,
      CMD_ARM   = 3'd1,
      CMD_DATA  = 3'd2,
      CMD_NUDGE = 3'd3,
      CMD_RESET = 3'd4
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLED = 2'd0,
      CSR_STEP    = 2'd1,
      CSR_DELAY   = 2'd2
   } csr_addr_type;

   // quotient by three for values up to 64, via multiply by 43 / 128
   function automatic logic [4:0] div3_small(input logic [6:0] x);
      logic [12:0] prod;
      prod = 13'(x) * 13'd43;
      return prod[11:7];
   endfunction

endpackage

[sv/syt_timestamp_generator_core.sv]
// syt timestamp generator: one request beat in, one syt beat out
// a request beat passes through the input register and then the result register to response valid
// throughput: one beat per cycle while rsp_tready holds; offset update is a single pass of short adds and selects
// position kept as bus cycles mod 64000 plus ticks mod 3072, so the syt is a plain slice
// reset is synchronous: clears offset, flags, both pipeline valids and reloads csr defaults
module syt_timestamp_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rx_syt[15:0], transmit_cycle[28:16], samples_in_packet[36:29], nudge_delta[52:37]
   input  logic [syt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[2:0]
   input  logic [syt_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // syt[15:0]
   output logic [syt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [syt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [syt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   // configuration, kept pre-split into cycles and ticks
   logic                          enabled_ff, enabled_in;
   logic                          step_nz_ff, step_nz_in;
   logic [4:0]                    step_cyc_ff, step_cyc_in;
   logic [syt_pkg::TK_W-1:0]      step_tk_ff, step_tk_in;
   logic [syt_pkg::CYC_W-1:0]     delay_cyc_ff, delay_cyc_in;
   logic [syt_pkg::TK_W-1:0]      delay_tk_ff, delay_tk_in;

   // timeline state
   logic [syt_pkg::CYC_W-1:0]     cyc_ff, cyc_in;
   logic [syt_pkg::TK_W-1:0]      tk_ff, tk_in;
   logic                          seeded_ff, seeded_in;
   logic                          pending_ff, pending_in;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [2:0]                    in_cmd_ff, in_cmd_in;
   logic [15:0]                   in_rx_syt_ff, in_rx_syt_in;
   logic [12:0]                   in_tx_cycle_ff, in_tx_cycle_in;
   logic [7:0]                    in_samples_ff, in_samples_in;
   logic signed [15:0]            in_delta_ff, in_delta_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [syt_pkg::RSP_DATA_W-1:0] syt_ff, syt_in;

   logic                          req_accept;
   logic                          advance;

   // csr split helpers
   logic [17:0]                   dly_q1;
   logic [37:0]                   dly_prod;
   logic [16:0]                   dly_q;
   logic [17:0]                   dly_rem;
   logic [5:0]                    stp_q1;
   logic [4:0]                    stp_q;
   logic [5:0]                    stp_rem;

   // datapath
   logic                          seed_carry;
   logic [syt_pkg::TK_W-1:0]      seed_tk;
   logic [3:0]                    seed_cyc;
   logic [12:0]                   anc_c;
   logic [16:0]                   anc_sum;
   logic [syt_pkg::CYC_W-1:0]     anc_cyc;
   logic [syt_pkg::CYC_W-1:0]     base_cyc;
   logic [syt_pkg::TK_W-1:0]      base_tk;
   logic [12:0]                   adv_tsum;
   logic                          adv_carry;
   logic [syt_pkg::TK_W-1:0]      adv_tk;
   logic [16:0]                   adv_csum;
   logic [syt_pkg::CYC_W-1:0]     adv_cyc;
   logic [16:0]                   nud_u;
   logic [6:0]                    nud_hi;
   logic [4:0]                    nud_q;
   logic [6:0]                    nud_rem;
   logic [syt_pkg::TK_W-1:0]      nud_r;
   logic [12:0]                   nud_tsum;
   logic                          nud_carry;
   logic [syt_pkg::TK_W-1:0]      nud_tk;
   logic [16:0]                   nud_csum;
   logic [syt_pkg::CYC_W-1:0]     nud_cyc;
   logic                          data_ok;

   assign req_accept = req_tvalid && req_tready;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = syt_ff;

   // csr writes: set the enable flag, split delay and step into whole cycles and leftover ticks
   always_comb begin
      dly_q1  = csr_wdata[27:10];
      dly_prod = 38'(dly_q1) * 38'(syt_pkg::DIV3_MUL);
      dly_q   = dly_prod[36:20];
      dly_rem = dly_q1 - 18'(dly_q) * 18'd3;
      stp_q1  = csr_wdata[15:10];
      stp_q   = syt_pkg::div3_small({1'b0, stp_q1});
      stp_rem = stp_q1 - 6'(stp_q) * 6'd3;

      enabled_in   = enabled_ff;
      step_nz_in   = step_nz_ff;
      step_cyc_in  = step_cyc_ff;
      step_tk_in   = step_tk_ff;
      delay_cyc_in = delay_cyc_ff;
      delay_tk_in  = delay_tk_ff;
      if (csr_we) begin
         unique case (csr_addr)
            syt_pkg::CSR_ENABLED: begin
               enabled_in = csr_wdata[0];
            end
            syt_pkg::CSR_STEP: begin
               step_nz_in  = (csr_wdata[15:0] != 16'd0);
               step_cyc_in = stp_q;
               step_tk_in  = {stp_rem[1:0], csr_wdata[9:0]};
            end
            syt_pkg::CSR_DELAY: begin
               delay_tk_in = {dly_rem[1:0], csr_wdata[9:0]};
               if (dly_q >= 17'(syt_pkg::WRAP_CYCLES)) begin
                  delay_cyc_in = 16'(dly_q - 17'(syt_pkg::WRAP_CYCLES));
               end else begin
                  delay_cyc_in = dly_q[15:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // offset datapath
   always_comb begin
      // seed: ticks of 3072 or more carry into the 4-bit cycle
      seed_carry = in_rx_syt_ff[11:0] >= 12'(syt_pkg::TICKS_PER_CYCLE);
      seed_tk    = seed_carry ? in_rx_syt_ff[11:0] - 12'(syt_pkg::TICKS_PER_CYCLE)
                              : in_rx_syt_ff[11:0];
      seed_cyc   = in_rx_syt_ff[15:12] + 4'(seed_carry);

      // anchor to transmit cycle plus delay
      anc_c   = (in_tx_cycle_ff >= 13'(syt_pkg::CYCLES_PER_SECOND))
              ? in_tx_cycle_ff - 13'(syt_pkg::CYCLES_PER_SECOND) : in_tx_cycle_ff;
      anc_sum = 17'(anc_c) + 17'(delay_cyc_ff);
      anc_cyc = (anc_sum >= 17'(syt_pkg::WRAP_CYCLES))
              ? 16'(anc_sum - 17'(syt_pkg::WRAP_CYCLES)) : anc_sum[15:0];

      base_cyc = pending_ff ? anc_cyc : cyc_ff;
      base_tk  = pending_ff ? delay_tk_ff : tk_ff;

      // advance by one packet step
      adv_tsum  = 13'(base_tk) + 13'(step_tk_ff);
      adv_carry = adv_tsum >= 13'(syt_pkg::TICKS_PER_CYCLE);
      adv_tk    = adv_carry ? 12'(adv_tsum - 13'(syt_pkg::TICKS_PER_CYCLE)) : adv_tsum[11:0];
      adv_csum  = 17'(base_cyc) + 17'(step_cyc_ff) + 17'(adv_carry);
      adv_cyc   = (adv_csum >= 17'(syt_pkg::WRAP_CYCLES))
                ? 16'(adv_csum - 17'(syt_pkg::WRAP_CYCLES)) : adv_csum[15:0];

      // nudge: bias the delta positive, split it, then take the bias off the cycles
      nud_u     = 17'(syt_pkg::NUDGE_BIAS_TICKS) + 17'(in_delta_ff);
      nud_hi    = nud_u[16:10];
      nud_q     = syt_pkg::div3_small(nud_hi);
      nud_rem   = nud_hi - 7'(nud_q) * 7'd3;
      nud_r     = {nud_rem[1:0], nud_u[9:0]};
      nud_tsum  = 13'(tk_ff) + 13'(nud_r);
      nud_carry = nud_tsum >= 13'(syt_pkg::TICKS_PER_CYCLE);
      nud_tk    = nud_carry ? 12'(nud_tsum - 13'(syt_pkg::TICKS_PER_CYCLE)) : nud_tsum[11:0];
      nud_csum  = 17'(cyc_ff) + 17'(nud_q) + 17'(nud_carry);
      if (nud_csum >= 17'(syt_pkg::WRAP_CYCLES + syt_pkg::NUDGE_BIAS_CYCLES)) begin
         nud_cyc = 16'(nud_csum - 17'(syt_pkg::WRAP_CYCLES + syt_pkg::NUDGE_BIAS_CYCLES));
      end else if (nud_csum >= 17'(syt_pkg::NUDGE_BIAS_CYCLES)) begin
         nud_cyc = 16'(nud_csum - 17'(syt_pkg::NUDGE_BIAS_CYCLES));
      end else begin
         nud_cyc = 16'(nud_csum + 17'(syt_pkg::WRAP_CYCLES - syt_pkg::NUDGE_BIAS_CYCLES));
      end

      data_ok = enabled_ff && seeded_ff && (in_samples_ff != 8'd0) && step_nz_ff;
   end

   // command decode and handshake
   always_comb begin
      cyc_in     = cyc_ff;
      tk_in      = tk_ff;
      seeded_in  = seeded_ff;
      pending_in = pending_ff;
      syt_in     = syt_ff;

      if (advance) begin
         syt_in = syt_pkg::NO_INFO;
         unique case (in_cmd_ff)
            syt_pkg::CMD_RESET: begin
               cyc_in     = '0;
               tk_in      = '0;
               seeded_in  = 1'b0;
               pending_in = 1'b0;
            end
            syt_pkg::CMD_SEED: begin
               if (enabled_ff) begin
                  cyc_in     = 16'(seed_cyc);
                  tk_in      = seed_tk;
                  seeded_in  = 1'b1;
                  pending_in = 1'b0;
               end
            end
            syt_pkg::CMD_ARM: begin
               if (enabled_ff) begin
                  seeded_in  = 1'b1;
                  pending_in = 1'b1;
               end
            end
            syt_pkg::CMD_DATA: begin
               if (data_ok) begin
                  syt_in     = {base_cyc[3:0], base_tk};
                  cyc_in     = adv_cyc;
                  tk_in      = adv_tk;
                  pending_in = 1'b0;
               end
            end
            syt_pkg::CMD_NUDGE: begin
               if (enabled_ff && seeded_ff && (in_delta_ff != 16'sd0)) begin
                  cyc_in = nud_cyc;
                  tk_in  = nud_tk;
               end
            end
            default: begin
            end
         endcase
      end

      in_cmd_in      = in_cmd_ff;
      in_rx_syt_in   = in_rx_syt_ff;
      in_tx_cycle_in = in_tx_cycle_ff;
      in_samples_in  = in_samples_ff;
      in_delta_in    = in_delta_ff;
      if (req_accept) begin
         in_cmd_in      = req_tuser[2:0];
         in_rx_syt_in   = req_tdata[15:0];
         in_tx_cycle_in = req_tdata[28:16];
         in_samples_in  = req_tdata[36:29];
         in_delta_in    = req_tdata[52:37];
      end

      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         step_nz_ff   <= 1'b1;
         step_cyc_ff  <= 5'd1;
         step_tk_ff   <= 12'd1024;
         delay_cyc_ff <= '0;
         delay_tk_ff  <= '0;
         cyc_ff       <= '0;
         tk_ff        <= '0;
         seeded_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         step_nz_ff   <= step_nz_in;
         step_cyc_ff  <= step_cyc_in;
         step_tk_ff   <= step_tk_in;
         delay_cyc_ff <= delay_cyc_in;
         delay_tk_ff  <= delay_tk_in;
         cyc_ff       <= cyc_in;
         tk_ff        <= tk_in;
         seeded_ff    <= seeded_in;
         pending_ff   <= pending_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff      <= in_cmd_in;
      in_rx_syt_ff   <= in_rx_syt_in;
      in_tx_cycle_ff <= in_tx_cycle_in;
      in_samples_ff  <= in_samples_in;
      in_delta_ff    <= in_delta_in;
      syt_ff         <= syt_in;
   end

   `SYT_ASSERT(a_tk_range, clock, reset, tk_ff < 12'(syt_pkg::TICKS_PER_CYCLE), "tick count out of range")
   `SYT_ASSERT(a_cyc_range, clock, reset, cyc_ff < 16'(syt_pkg::WRAP_CYCLES), "cycle count past eight seconds")
   `SYT_ASSERT(a_pending_seeded, clock, reset, pending_ff |-> seeded_ff, "anchor pending while unseeded")
   `SYT_ASSERT(a_drain, clock, reset, (out_valid_ff && rsp_tready && !in_valid_ff) |=> !out_valid_ff, "result beat repeated")
   `SYT_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!out_valid_ff && !in_valid_ff && !seeded_ff), "reset left pipeline or timeline active")

endmodule
